>>> rtl/tspp_pkg.sv
// ----------------------------------------------------------------------------
// Trajectory servo PWM player package
// Shared widths, request and register codes, reset values and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tspp_pkg;

   // Default number of points per bank
   localparam int TSPP_POINTS = 64;

   // Field widths
   localparam int REQ_TYPE_W = 2;
   localparam int PIDX_IN_W  = 6;
   localparam int POS_W      = 16;
   localparam int TICK_W     = 16;
   localparam int CMP_W      = 16;
   localparam int SEG_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int GAIN_W     = 12;
   localparam int MAXD_W     = 15;
   localparam int MID_W      = 16;
   localparam int DB_W       = 10;

   // Shared divider: quotient bits per pass and step counter width
   localparam int QBITS  = 15;
   localparam int QCNT_W = 4;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_COMMIT = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_P_GAIN_NUM = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_P_GAIN_DEN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DRIVE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MID  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_MID1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_MID2 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_ENABLE = 3'd7;

   // Register reset values
   localparam logic [GAIN_W-1:0] RST_P_GAIN_NUM = 12'd1;
   localparam logic [GAIN_W-1:0] RST_P_GAIN_DEN = 12'd1;
   localparam logic [MAXD_W-1:0] RST_MAX_DRIVE  = 15'd1000;
   localparam logic [MID_W-1:0]  RST_DRIVE_MID  = 16'd1500;
   localparam logic [DB_W-1:0]   RST_DEADBAND   = 10'd0;
   localparam logic [MID_W-1:0]  RST_SERVO_MID  = 16'd1500;
   localparam logic              RST_RUN_ENABLE = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic do_load;     // write a point into the back bank
      logic do_commit;   // mark back bank ready with its length
      logic tick_begin;  // capture encoder, swap banks if due
      logic tick_eval;   // decide update, start index division
      logic rd_en;       // read the selected point
      logic mul_en;      // form the gain product
      logic drv_start;   // start the gain division
      logic out_load;    // load the result register
   } tspp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic tick_active; // run mode and ticks remain
      logic div_busy;    // shared divider still iterating
   } tspp_stat_type;

endpackage

>>> rtl/tspp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tspp_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tspp_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle. The caller preloads a partial
// remainder that is already below the divisor plus the low numerator bits.
// ----------------------------------------------------------------------------
module tspp_div
   import tspp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [15:0]       rem_init,
   input  logic [QBITS-1:0]  bits_init,
   input  logic [15:0]       divisor,
   input  logic [QCNT_W-1:0] steps,
   output logic              busy,
   output logic [QBITS-1:0]  quotient
);

   logic              busy_ff, busy_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]       rem_ff, rem_in;
   logic [QBITS-1:0]  bits_ff, bits_in;
   logic [15:0]       div_ff, div_in;
   logic [QBITS-1:0]  quo_ff, quo_in;
   logic [16:0]       rem_shift;
   logic [16:0]       rem_diff;
   logic              ge;

   // One restoring step
   always_comb begin
      rem_shift = {rem_ff, bits_ff[QBITS-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      ge        = (rem_shift >= {1'b0, div_ff});
   end

   // Next state
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = rem_init;
         bits_in = bits_init;
         div_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_diff[15:0] : rem_shift[15:0];
         bits_in = {bits_ff[QBITS-2:0], 1'b0};
         quo_in  = {quo_ff[QBITS-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == QCNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/tspp_ctrl.sv
// ----------------------------------------------------------------------------
// Trajectory player controller
// Sequences one request at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module tspp_ctrl
   import tspp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [REQ_TYPE_W-1:0] req_type,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  tspp_stat_type         stat,
   output tspp_cmd_type          cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TICK  = 3'd1;
   localparam logic [2:0] S_IDIV  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_DLOAD = 3'd5;
   localparam logic [2:0] S_DDIV  = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Sequence the request
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_type)
                  REQ_TICK: begin
                     cmd.tick_begin = 1'b1;
                     state_in       = S_TICK;
                  end
                  REQ_LOAD:   cmd.do_load   = 1'b1;
                  REQ_COMMIT: cmd.do_commit = 1'b1;
                  default: ;
               endcase
            end
         end
         S_TICK: begin
            cmd.tick_eval = 1'b1;
            state_in      = stat.tick_active ? S_IDIV : S_OUT;
         end
         S_IDIV: begin
            if (!stat.div_busy) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.drv_start = 1'b1;
            state_in      = S_DDIV;
         end
         S_DDIV: begin
            if (!stat.div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold result valid until transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/tspp_dp.sv
// ----------------------------------------------------------------------------
// Trajectory player datapath
// Configuration registers, bank and tick state, point memory, shared divider
// and the compare arithmetic feeding the result register.
// ----------------------------------------------------------------------------
module tspp_dp
   import tspp_pkg::*;
#(
   parameter int POINTS = TSPP_POINTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tspp_cmd_type          cmd,
   output tspp_stat_type         stat,
   input  logic [PIDX_IN_W-1:0]  req_point_index,
   input  logic signed [POS_W-1:0] req_pos_drive,
   input  logic signed [POS_W-1:0] req_pos_servo_1,
   input  logic signed [POS_W-1:0] req_pos_servo_2,
   input  logic signed [POS_W-1:0] req_encoder_count,
   input  logic [TICK_W-1:0]     req_segment_ticks,
   input  logic                  csr_wr,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [CMP_W-1:0]      rsp_servo_compare_1,
   output logic [CMP_W-1:0]      rsp_servo_compare_2,
   output logic [CMP_W-1:0]      rsp_drive_compare,
   output logic                  rsp_updated,
   output logic [SEG_W-1:0]      rsp_segment_count
);

   localparam int PW      = $clog2(POINTS);
   localparam int NW      = TICK_W + PW;
   localparam int AW      = PW + 1;
   localparam int DEPTH   = 2 << PW;
   localparam int ROW_W   = 3 * POS_W;
   localparam int SUM_W   = POS_W + 1;
   localparam int PROD_W  = SUM_W + GAIN_W + 1;
   localparam int MAG_W   = 28;
   localparam int EXT_W   = 18;

   // Configuration registers
   logic [GAIN_W-1:0] p_gain_num_ff;
   logic [GAIN_W-1:0] p_gain_den_ff;
   logic [MAXD_W-1:0] max_drive_ff;
   logic [MID_W-1:0]  drive_mid_ff;
   logic [DB_W-1:0]   deadband_ff;
   logic [MID_W-1:0]  servo_mid_1_ff;
   logic [MID_W-1:0]  servo_mid_2_ff;
   logic              run_enable_ff;

   // Player state
   logic              front_bank_ff, front_bank_in;
   logic              bank_ready_ff, bank_ready_in;
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [TICK_W-1:0] tick_limit_ff, tick_limit_in;
   logic [TICK_W-1:0] pending_ff, pending_in;
   logic [SEG_W-1:0]  swap_cnt_ff, swap_cnt_in;
   logic              upd_ff;
   logic              tick_active;

   // Per-tick working registers
   logic signed [POS_W-1:0]  enc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     big_ff;
   logic                     neg_ff;

   // Result registers
   logic [CMP_W-1:0] out_s1_ff, out_s2_ff, out_drv_ff;
   logic             out_upd_ff;
   logic [SEG_W-1:0] out_seg_ff;

   // Point memory signals
   logic [31:0]      pi_ext;
   logic             pi_ok;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [AW-1:0]    ram_raddr;
   logic [ROW_W-1:0] ram_wdata;
   logic [ROW_W-1:0] ram_rdata;

   // Divider signals
   logic              div_start;
   logic [15:0]       div_rem;
   logic [QBITS-1:0]  div_bits;
   logic [15:0]       div_divisor;
   logic [QCNT_W-1:0] div_steps;
   logic              div_busy;
   logic [QBITS-1:0]  div_q;

   // Arithmetic
   logic [NW-1:0]            idx_num;
   logic [PW-1:0]            idx_q;
   logic [PW-1:0]            idx;
   logic [GAIN_W-1:0]        den_eff;
   logic signed [SUM_W-1:0]  pos_sum;
   logic signed [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0]        prod_abs;
   logic [MAG_W-1:0]         mag;
   logic                     mag_big;
   logic [MAXD_W-1:0]        corr;
   logic [EXT_W-1:0]         corr_db;
   logic signed [EXT_W-1:0]  drv_sum;
   logic signed [EXT_W-1:0]  s1_sum;
   logic signed [EXT_W-1:0]  s2_sum;
   logic signed [POS_W-1:0]  row_drive, row_s1, row_s2;

   function automatic logic [CMP_W-1:0] sat16(input logic signed [EXT_W-1:0] v);
      logic [CMP_W-1:0] r;
      if (v[EXT_W-1]) begin
         r = '0;
      end else if (v[EXT_W-2:CMP_W] != '0) begin
         r = '1;
      end else begin
         r = v[CMP_W-1:0];
      end
      return r;
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         p_gain_num_ff  <= RST_P_GAIN_NUM;
         p_gain_den_ff  <= RST_P_GAIN_DEN;
         max_drive_ff   <= RST_MAX_DRIVE;
         drive_mid_ff   <= RST_DRIVE_MID;
         deadband_ff    <= RST_DEADBAND;
         servo_mid_1_ff <= RST_SERVO_MID;
         servo_mid_2_ff <= RST_SERVO_MID;
         run_enable_ff  <= RST_RUN_ENABLE;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_P_GAIN_NUM: p_gain_num_ff  <= csr_data[GAIN_W-1:0];
            CSR_P_GAIN_DEN: p_gain_den_ff  <= csr_data[GAIN_W-1:0];
            CSR_MAX_DRIVE:  max_drive_ff   <= csr_data[MAXD_W-1:0];
            CSR_DRIVE_MID:  drive_mid_ff   <= csr_data[MID_W-1:0];
            CSR_DEADBAND:   deadband_ff    <= csr_data[DB_W-1:0];
            CSR_SERVO_MID1: servo_mid_1_ff <= csr_data[MID_W-1:0];
            CSR_SERVO_MID2: servo_mid_2_ff <= csr_data[MID_W-1:0];
            CSR_RUN_ENABLE: run_enable_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign tick_active = run_enable_ff && (tick_count_ff < tick_limit_ff);

   // Bank swap, commit and tick counting
   always_comb begin
      front_bank_in = front_bank_ff;
      bank_ready_in = bank_ready_ff;
      tick_count_in = tick_count_ff;
      tick_limit_in = tick_limit_ff;
      pending_in    = pending_ff;
      swap_cnt_in   = swap_cnt_ff;
      if (cmd.do_commit) begin
         bank_ready_in = 1'b1;
         pending_in    = req_segment_ticks;
      end
      if (cmd.tick_begin && run_enable_ff && bank_ready_ff &&
          (tick_count_ff >= tick_limit_ff)) begin
         front_bank_in = !front_bank_ff;
         bank_ready_in = 1'b0;
         tick_count_in = '0;
         tick_limit_in = pending_ff;
         swap_cnt_in   = swap_cnt_ff + 1'b1;
      end
      if (cmd.tick_eval && tick_active && (tick_count_ff != '1)) begin
         tick_count_in = tick_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_bank_ff <= 1'b0;
         bank_ready_ff <= 1'b0;
         tick_count_ff <= '0;
         tick_limit_ff <= '0;
         pending_ff    <= '0;
         swap_cnt_ff   <= '0;
         upd_ff        <= 1'b0;
      end else begin
         front_bank_ff <= front_bank_in;
         bank_ready_ff <= bank_ready_in;
         tick_count_ff <= tick_count_in;
         tick_limit_ff <= tick_limit_in;
         pending_ff    <= pending_in;
         swap_cnt_ff   <= swap_cnt_in;
         if (cmd.tick_eval) begin
            upd_ff <= tick_active;
         end
      end
   end

   // Point memory: write back bank, read front bank
   assign pi_ext    = 32'(req_point_index);
   assign pi_ok     = (pi_ext < 32'(POINTS));
   assign ram_we    = cmd.do_load && pi_ok;
   assign ram_waddr = {!front_bank_ff, pi_ext[PW-1:0]};
   assign ram_wdata = {req_pos_drive, req_pos_servo_1, req_pos_servo_2};

   // Clamp index into the bank
   assign idx_q = div_q[PW-1:0];
   assign idx   = (32'(idx_q) >= 32'(POINTS)) ? PW'(POINTS - 1) : idx_q;
   assign ram_raddr = {front_bank_ff, idx};

   tspp_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign row_drive = ram_rdata[ROW_W-1:2*POS_W];
   assign row_s1    = ram_rdata[2*POS_W-1:POS_W];
   assign row_s2    = ram_rdata[POS_W-1:0];

   // Index numerator tick*POINTS, quotient is below POINTS
   assign idx_num = NW'(tick_count_ff) * NW'(POINTS);

   // Gain product and its magnitude
   assign den_eff  = (p_gain_den_ff == '0) ? GAIN_W'(1) : p_gain_den_ff;
   assign pos_sum  = $signed({row_drive[POS_W-1], row_drive}) +
                     $signed({enc_ff[POS_W-1], enc_ff});
   assign prod_in  = pos_sum * $signed({1'b0, p_gain_num_ff});
   assign prod_abs = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign mag      = prod_abs[MAG_W-1:0];
   // Quotient of 2^15 or more always exceeds the clamp
   assign mag_big  = (mag >= MAG_W'({den_eff, {QBITS{1'b0}}}));

   // Divider operand select
   always_comb begin
      div_start   = cmd.drv_start || (cmd.tick_eval && tick_active);
      div_rem     = idx_num[NW-1:PW];
      div_bits    = QBITS'(idx_num[PW-1:0]) << (QBITS - PW);
      div_divisor = tick_limit_ff;
      div_steps   = QCNT_W'(PW);
      if (cmd.drv_start) begin
         div_rem     = 16'(mag[MAG_W-1:QBITS]);
         div_bits    = mag[QBITS-1:0];
         div_divisor = 16'(den_eff);
         div_steps   = QCNT_W'(QBITS);
      end
   end

   tspp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .rem_init  (div_rem),
      .bits_init (div_bits),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .busy      (div_busy),
      .quotient  (div_q)
   );

   assign stat.tick_active = tick_active;
   assign stat.div_busy    = div_busy;

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.tick_begin) begin
         enc_ff <= req_encoder_count;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.drv_start) begin
         big_ff <= mag_big;
         neg_ff <= prod_ff[PROD_W-1];
      end
   end

   // Clamp correction, add signed deadband, saturate compares
   always_comb begin
      corr    = (big_ff || (div_q > max_drive_ff)) ? max_drive_ff : div_q;
      corr_db = EXT_W'(corr) + EXT_W'(deadband_ff);
      if (corr == '0) begin
         drv_sum = $signed(EXT_W'(drive_mid_ff));
      end else if (neg_ff) begin
         drv_sum = $signed(EXT_W'(drive_mid_ff)) - $signed(corr_db);
      end else begin
         drv_sum = $signed(EXT_W'(drive_mid_ff)) + $signed(corr_db);
      end
      s1_sum = $signed(EXT_W'(servo_mid_1_ff)) +
               $signed({row_s1[POS_W-1], row_s1, 1'b0});
      s2_sum = $signed(EXT_W'(servo_mid_2_ff)) +
               $signed({row_s2[POS_W-1], row_s2, 1'b0});
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_upd_ff <= upd_ff;
         out_seg_ff <= swap_cnt_ff;
         if (upd_ff) begin
            out_s1_ff  <= sat16(s1_sum);
            out_s2_ff  <= sat16(s2_sum);
            out_drv_ff <= sat16(drv_sum);
         end else begin
            out_s1_ff  <= '0;
            out_s2_ff  <= '0;
            out_drv_ff <= '0;
         end
      end
   end

   assign rsp_servo_compare_1 = out_s1_ff;
   assign rsp_servo_compare_2 = out_s2_ff;
   assign rsp_drive_compare   = out_drv_ff;
   assign rsp_updated         = out_upd_ff;
   assign rsp_segment_count   = out_seg_ff;

endmodule

>>> rtl/trajectory_servo_pwm_player_unit.sv
// Double-buffered trajectory player for one drive joint and two servos. Load and
// commit requests and ignored request codes are taken in the idle state. A tick
// request blocks further requests until it ends. One that produces no new values
// (freefall or segment finished) passes only through the tick and output states;
// otherwise the single shared bit-serial divider first forms the log2(POINTS)-bit
// point index and then the 15-bit gain quotient, with the point memory read and
// the gain multiply in between. The result register lets
// the next request in while a result still waits for transfer; a tick that
// finishes before that transfer holds in its last step. Configuration writes are
// taken in every cycle and must only be issued while the block is idle.
//
// ----------------------------------------------------------------------------
// Trajectory servo PWM player top level
// Ties the controller, the datapath and the configuration port together.
// ----------------------------------------------------------------------------
module trajectory_servo_pwm_player_unit
   import tspp_pkg::*;
#(
   parameter int POINTS = TSPP_POINTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [REQ_TYPE_W-1:0]   req_type,
   input  logic [PIDX_IN_W-1:0]    req_point_index,
   input  logic signed [POS_W-1:0] req_pos_drive,
   input  logic signed [POS_W-1:0] req_pos_servo_1,
   input  logic signed [POS_W-1:0] req_pos_servo_2,
   input  logic signed [POS_W-1:0] req_encoder_count,
   input  logic [TICK_W-1:0]       req_segment_ticks,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CMP_W-1:0]        rsp_servo_compare_1,
   output logic [CMP_W-1:0]        rsp_servo_compare_2,
   output logic [CMP_W-1:0]        rsp_drive_compare,
   output logic                    rsp_updated,
   output logic [SEG_W-1:0]        rsp_segment_count,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   tspp_cmd_type  cmd;
   tspp_stat_type stat;

   // Register writes always complete in one transfer
   assign csr_ready = 1'b1;

   tspp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   tspp_dp #(
      .POINTS (POINTS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_point_index     (req_point_index),
      .req_pos_drive       (req_pos_drive),
      .req_pos_servo_1     (req_pos_servo_1),
      .req_pos_servo_2     (req_pos_servo_2),
      .req_encoder_count   (req_encoder_count),
      .req_segment_ticks   (req_segment_ticks),
      .csr_wr              (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_servo_compare_1 (rsp_servo_compare_1),
      .rsp_servo_compare_2 (rsp_servo_compare_2),
      .rsp_drive_compare   (rsp_drive_compare),
      .rsp_updated         (rsp_updated),
      .rsp_segment_count   (rsp_segment_count)
   );

endmodule

>>> rtl/tspp_checker.sv
// ----------------------------------------------------------------------------
// Trajectory player port checker
// Watches the top level ports for result ordering and stall behavior.
// ----------------------------------------------------------------------------
module tspp_checker
   import tspp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [REQ_TYPE_W-1:0] req_type,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CMP_W-1:0]      rsp_servo_compare_1,
   input logic [CMP_W-1:0]      rsp_servo_compare_2,
   input logic [CMP_W-1:0]      rsp_drive_compare,
   input logic                  rsp_updated,
   input logic [SEG_W-1:0]      rsp_segment_count
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_servo_compare_1) &&
      $stable(rsp_servo_compare_2) && $stable(rsp_drive_compare) &&
      $stable(rsp_updated) && $stable(rsp_segment_count))
      else $error("result changed while stalled");

   // A result without new values carries zero compares
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_updated |->
      rsp_servo_compare_1 == '0 && rsp_servo_compare_2 == '0 &&
      rsp_drive_compare == '0)
      else $error("non-updated result with nonzero compare");

   // Loads, commits and unknown requests never raise a result
   a_no_rsp_non_tick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type != REQ_TICK |=> !$rose(rsp_valid))
      else $error("result after a non-tick request");

   // A tick in progress blocks the next request
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_TICK |=> !req_ready)
      else $error("request taken during a tick");

endmodule

bind trajectory_servo_pwm_player_unit tspp_checker u_tspp_checker (.*);
